### hw/rtl/dsli_pkg.sv
package dsli_pkg;

   // Command codes on the request channel
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DUMP   = 1'b1;

   // Status codes on the response channel
   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_DUMPED   = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   localparam int VALUE_W = 32;

   typedef struct packed {
      logic                      command;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] entry;
      logic [1:0]                status;
      logic                      last;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       latch_req;
      logic       insert;
      logic       rotate;
      logic       load_rsp;
      logic       take_entry;
      logic [1:0] rsp_status;
      logic       rsp_last;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic command;
      logic full;
      logic empty;
      logic dump_last;
      logic rsp_free;
   } dp_status_type;

endpackage

### hw/rtl/descending_sorted_list_insert_unit.sv
// Channel   Direction  Ports                              Carries
// request   in         req_valid, req_ready, req_payload  command, value
// response  out        rsp_valid, rsp_ready, rsp_payload  entry, status, last
//
// Insert: accept, then one parallel compare-and-shift over the cell row that also
// loads the response register (when full, only the response, with status full).
// Dump: accept, then one result per entry; the row rotates one place per result.
// Reset (synchronous) empties the store; cell contents are not cleared.
// A stalled response holds the controller; a new request is taken while the
// last response still waits in the output register.
module descending_sorted_list_insert_unit
   import dsli_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   ctl_cmd_type   cmd;
   dp_status_type stat;

   dsli_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dsli_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

### hw/rtl/dsli_datapath.sv
module dsli_datapath
   import dsli_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_payload,
   input  ctl_cmd_type   cmd,
   output dp_status_type stat,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output rsp_type       rsp_payload
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   req_type                   req_ff;
   logic signed [VALUE_W-1:0] cell_ff [DEPTH];
   logic signed [VALUE_W-1:0] cell_in [DEPTH];
   logic [DEPTH-1:0]          gt;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          step_ff;
   logic [CNT_W-1:0]          count_m1;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   assign count_m1 = count_ff - CNT_W'(1);

   // Per-cell compare: valid cells holding a larger value stay put
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (cell_ff[i] > req_ff.value);
      end
   end

   // Next cell contents for insert (shift down) or dump (rotate up within count)
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
         if (cmd.insert) begin
            if (gt[i]) begin
               cell_in[i] = cell_ff[i];
            end else if (i == 0) begin
               cell_in[i] = req_ff.value;
            end else if (gt[i-1]) begin
               cell_in[i] = req_ff.value;
            end else begin
               cell_in[i] = cell_ff[i-1];
            end
         end else if (cmd.rotate) begin
            if (CNT_W'(i) == count_m1) begin
               cell_in[i] = cell_ff[0];
            end else if (i < DEPTH - 1) begin
               cell_in[i] = cell_ff[(i + 1) % DEPTH];
            end
         end
      end
   end

   // Cell row, no reset needed
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   // Hold the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_payload;
      end
   end

   // Track fill count and dump position
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         step_ff  <= '0;
      end else begin
         if (cmd.insert) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.latch_req) begin
            step_ff <= '0;
         end else if (cmd.rotate) begin
            step_ff <= step_ff + CNT_W'(1);
         end
      end
   end

   // Output register: load a result, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.entry  <= cmd.take_entry ? cell_ff[0] : '0;
         rsp_ff.status <= cmd.rsp_status;
         rsp_ff.last   <= cmd.rsp_last;
      end
   end

   assign stat.command   = req_ff.command;
   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.empty     = (count_ff == '0);
   assign stat.dump_last = (step_ff == count_m1);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### hw/rtl/dsli_controller.sv
module dsli_controller
   import dsli_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type stat,
   output ctl_cmd_type   cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Sequence one transaction at a time
   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.rsp_status = ST_INSERTED;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.command == CMD_INSERT) begin
               if (stat.rsp_free) begin
                  cmd.load_rsp   = 1'b1;
                  cmd.rsp_last   = 1'b1;
                  cmd.insert     = !stat.full;
                  cmd.rsp_status = stat.full ? ST_FULL : ST_INSERTED;
                  state_in       = S_IDLE;
               end
            end else if (stat.empty) begin
               if (stat.rsp_free) begin
                  cmd.load_rsp   = 1'b1;
                  cmd.rsp_last   = 1'b1;
                  cmd.rsp_status = ST_EMPTY;
                  state_in       = S_IDLE;
               end
            end else begin
               state_in = S_DUMP;
            end
         end
         S_DUMP: begin
            // Emit the head cell and rotate the row one place per result
            if (stat.rsp_free) begin
               cmd.load_rsp   = 1'b1;
               cmd.take_entry = 1'b1;
               cmd.rotate     = 1'b1;
               cmd.rsp_status = ST_DUMPED;
               cmd.rsp_last   = stat.dump_last;
               if (stat.dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
